/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only while reset is released
`define BPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define BPA_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BPA_ASSERT(lbl, prop, msg)
`define BPA_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

/* design/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Geometry, codes, list index helper and the list update command.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int FRAMES    = 4096;
    localparam int PW        = $clog2(FRAMES);   // frame number width
    localparam int LW        = PW + 1;           // link width, null marker included
    localparam int TOP_ORDER = 10;
    localparam int OW        = 4;                // order width
    localparam int LISTS     = 2 * (TOP_ORDER + 1);
    localparam int LIW       = $clog2(LISTS);
    localparam int CW        = 13;               // register / counter width

    localparam logic [LW-1:0] LINK_NONE = LW'(FRAMES);
    localparam logic [CW-1:0] COUNT_TOP = {CW{1'b1}};
    localparam logic [OW-1:0] NOT_HEAD  = 4'd15;

    // request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_ORDER   = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_TOTAL  = 2'd0;
    localparam logic [1:0] REG_KEND   = 2'd1;
    localparam logic [1:0] REG_DMA    = 2'd2;

    // one update of the free list table
    typedef struct packed {
        logic            head_we;
        logic            cnt_inc;
        logic            cnt_dec;
        logic [LIW-1:0]  idx;
        logic [LW-1:0]   head_val;
    } t_list_cmd;

    function automatic logic [LIW-1:0] list_idx(input logic z, input logic [OW-1:0] o);
        list_idx = z ? LIW'(o) + LIW'(TOP_ORDER + 1) : LIW'(o);
    endfunction

endpackage

/* design/bpa_ram.sv */
// ----------------------------------------------------------------------------
// Buddy allocator RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int W     = 13,
    parameter int DEPTH = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [W-1:0]              i_wdata,
    input  logic                      i_re,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [W-1:0]              o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* design/bpa_lists.sv */
// ----------------------------------------------------------------------------
// Buddy allocator free list table
// Head and count per (zone, order) list; a list is non-empty while its count is.
// ----------------------------------------------------------------------------
module bpa_lists (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpa_pkg::t_list_cmd         i_cmd,
    input  logic [bpa_pkg::LIW-1:0]    i_ridx,
    output logic [bpa_pkg::LW-1:0]     o_head,
    output logic [bpa_pkg::LISTS-1:0]  o_nonempty
);
    import bpa_pkg::*;

    logic [LW-1:0] r_head [LISTS];
    logic [CW-1:0] r_cnt  [LISTS];

    // list heads and saturating counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LISTS; i++) begin
                r_head[i] <= LINK_NONE;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_cmd.head_we) begin
                r_head[i_cmd.idx] <= i_cmd.head_val;
            end
            if (i_cmd.cnt_inc && r_cnt[i_cmd.idx] != COUNT_TOP) begin
                r_cnt[i_cmd.idx] <= r_cnt[i_cmd.idx] + 1'b1;
            end else if (i_cmd.cnt_dec && r_cnt[i_cmd.idx] != '0) begin
                r_cnt[i_cmd.idx] <= r_cnt[i_cmd.idx] - 1'b1;
            end
        end
    end

    assign o_head = r_head[i_ridx];

    always_comb begin
        for (int i = 0; i < LISTS; i++) begin
            o_nonempty[i] = (r_cnt[i] != '0);
        end
    end
endmodule

/* design/buddy_page_allocator.sv */
// ----------------------------------------------------------------------------
// Buddy page allocator
// Two-zone binary buddy allocator over page frames, one request at a time.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 4096 frames that marks
// every frame used; it takes no word until that ends. A request goes from
// idle straight to the output state when the order is too large or the frame
// is out of range or kernel-owned, and through a check or search state when
// the frame is already free or no block is found. An allocation finds a list,
// unlinks its head, then splits level by level, pushing each upper half that
// lies in range and dropping each half past the end; a free checks the frame,
// then reads and unlinks each free buddy as it merges, and pushes the result.
// Every split or merge step walks in turn through the ports of the frame state
// and link RAMs. A finished result waits in the output register while the next
// word is taken; a receiver stall on a held result keeps the block waiting.
`include "assert_macros.svh"

module buddy_page_allocator (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_func,
    input  logic [3:0]               i_order,
    input  logic                     i_zone,
    input  logic [11:0]              i_page,
    // result channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_status,
    output logic [11:0]              o_block_page,
    output logic [12:0]              o_used_pages,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [12:0]              i_cfg_data
);
    import bpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_A_FIND, S_A_SPLIT, S_UL1, S_UL2, S_PUSH2,
        S_F_CHK, S_F_BUD, S_F_BCHK, S_F_PUSH1, S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic            r_func, n_func;
    logic            r_zone, n_zone;
    logic [OW-1:0]   r_req, n_req;
    logic [OW-1:0]   r_order, n_order;
    logic [PW-1:0]   r_page, n_page;
    logic [PW-1:0]   r_in_page, n_in_page;
    logic [PW-1:0]   r_b, n_b;
    logic [LW-1:0]   r_h2, n_h2;
    logic [LIW-1:0]  r_li, n_li;
    logic [CW-1:0]   r_used, n_used;
    logic [1:0]      r_status, n_status;
    logic [PW-1:0]   r_res, n_res;
    logic [PW-1:0]   r_clr, n_clr;
    logic [CW-1:0]   r_total, r_kend, r_dma;
    logic            r_o_valid;
    logic [1:0]      r_o_status;
    logic [PW-1:0]   r_o_page;
    logic [CW-1:0]   r_o_used;

    logic [CW-1:0]   lim;
    logic            meta_we, meta_re, nx_we, nx_re, pv_we, pv_re;
    logic [PW-1:0]   meta_waddr, meta_raddr, nx_waddr, nx_raddr, pv_waddr, pv_raddr;
    logic [OW:0]     meta_wdata, meta_rd;
    logic [LW-1:0]   nx_wdata, pv_wdata, nx_rd, pv_rd;
    t_list_cmd       cmd;
    logic [LIW-1:0]  ridx;
    logic [LW-1:0]   head;
    logic [LISTS-1:0] nonempty;
    logic            found;
    logic [OW-1:0]   fc;
    logic [OW-1:0]   c1;
    logic [CW-1:0]   bsum;
    logic [PW-1:0]   bx;
    logic            out_load;
    logic            used_hold;
    logic            in_walk;

    assign lim = (r_total > CW'(FRAMES)) ? CW'(FRAMES) : r_total;

    bpa_ram #(.W(OW + 1), .DEPTH(FRAMES)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_waddr), .i_wdata(meta_wdata),
        .i_re(meta_re), .i_raddr(meta_raddr), .o_rdata(meta_rd)
    );
    bpa_ram #(.W(LW), .DEPTH(FRAMES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_re(nx_re), .i_raddr(nx_raddr), .o_rdata(nx_rd)
    );
    bpa_ram #(.W(LW), .DEPTH(FRAMES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_re(pv_re), .i_raddr(pv_raddr), .o_rdata(pv_rd)
    );
    bpa_lists u_lists (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_ridx(ridx),
        .o_head(head), .o_nonempty(nonempty)
    );

    // smallest non-empty order at or above the request in the chosen zone
    always_comb begin
        found = 1'b0;
        fc    = '0;
        for (int o = TOP_ORDER; o >= 0; o--) begin
            if (OW'(o) >= r_order && nonempty[list_idx(r_zone, OW'(o))]) begin
                found = 1'b1;
                fc    = OW'(o);
            end
        end
    end

    assign c1   = r_order - 1'b1;
    assign bsum = {1'b0, r_page} + (CW'(1) << c1);
    assign bx   = r_page ^ (PW'(1) << r_order);

    // sequencer: next state and RAM / list controls
    always_comb begin
        n_state = r_state;  n_func = r_func;     n_zone = r_zone;   n_req = r_req;
        n_order = r_order;  n_page = r_page;     n_in_page = r_in_page;
        n_b = r_b;          n_h2 = r_h2;         n_li = r_li;       n_used = r_used;
        n_status = r_status; n_res = r_res;      n_clr = r_clr;
        meta_we = 1'b0; meta_waddr = '0; meta_wdata = '0; meta_re = 1'b0; meta_raddr = '0;
        nx_we = 1'b0;   nx_waddr = '0;   nx_wdata = '0;   nx_re = 1'b0;   nx_raddr = '0;
        pv_we = 1'b0;   pv_waddr = '0;   pv_wdata = '0;   pv_re = 1'b0;   pv_raddr = '0;
        cmd = '0;
        ridx = '0;
        case (r_state)
            S_CLR: begin
                meta_we    = 1'b1;
                meta_waddr = r_clr;
                meta_wdata = {1'b1, OW'(0)};
                n_clr      = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                meta_re    = i_valid;
                meta_raddr = i_page;
                if (i_valid) begin
                    n_func = i_func;  n_req = i_order;  n_order = i_order;
                    n_zone = i_zone;  n_page = i_page;  n_in_page = i_page;
                    if (i_order > OW'(TOP_ORDER)) begin
                        n_status = ST_ORDER;
                        n_res    = (i_func == FUNC_FREE) ? i_page : '0;
                        n_state  = S_OUT;
                    end else if (i_func == FUNC_ALLOC) begin
                        n_state = S_A_FIND;
                    end else if ({1'b0, i_page} >= lim || {1'b0, i_page} < r_kend) begin
                        n_status = ST_IGNORED;
                        n_res    = i_page;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_F_CHK;
                    end
                end
            end
            S_A_FIND: begin
                ridx = list_idx(r_zone, fc);
                if (!found || head >= LINK_NONE) begin
                    n_status = ST_NOMEM;
                    n_res    = '0;
                    n_state  = S_OUT;
                end else begin
                    n_order  = fc;
                    n_page   = head[PW-1:0];
                    n_b      = head[PW-1:0];
                    n_li     = list_idx(r_zone, fc);
                    nx_re    = 1'b1;  nx_raddr = head[PW-1:0];
                    pv_re    = 1'b1;  pv_raddr = head[PW-1:0];
                    n_state  = S_UL1;
                end
            end
            // unlink r_b: bridge its neighbors
            S_UL1: begin
                cmd.idx     = r_li;
                cmd.cnt_dec = 1'b1;
                if (pv_rd < LINK_NONE) begin
                    nx_we = 1'b1;  nx_waddr = pv_rd[PW-1:0];  nx_wdata = nx_rd;
                end else begin
                    cmd.head_we  = 1'b1;
                    cmd.head_val = nx_rd;
                end
                if (nx_rd < LINK_NONE) begin
                    pv_we = 1'b1;  pv_waddr = nx_rd[PW-1:0];  pv_wdata = pv_rd;
                end
                n_state = S_UL2;
            end
            // unlink r_b: clear its own links
            S_UL2: begin
                nx_we = 1'b1;  nx_waddr = r_b;  nx_wdata = LINK_NONE;
                pv_we = 1'b1;  pv_waddr = r_b;  pv_wdata = LINK_NONE;
                if (r_func == FUNC_FREE) begin
                    meta_we    = 1'b1;
                    meta_waddr = r_b;
                    meta_wdata = {1'b0, NOT_HEAD};
                    n_page     = r_page & r_b;
                    n_order    = r_order + 1'b1;
                    n_state    = S_F_BUD;
                end else begin
                    n_state = S_A_SPLIT;
                end
            end
            // split one level and push the upper half when in range, or commit at the requested order
            S_A_SPLIT: begin
                ridx = list_idx(r_zone, c1);
                if (r_order > r_req) begin
                    n_order = c1;
                    if (bsum < lim) begin
                        meta_we = 1'b1;  meta_waddr = bsum[PW-1:0];  meta_wdata = {1'b0, c1};
                        nx_we = 1'b1;    nx_waddr = bsum[PW-1:0];    nx_wdata = head;
                        pv_we = 1'b1;    pv_waddr = bsum[PW-1:0];    pv_wdata = LINK_NONE;
                        cmd.idx      = list_idx(r_zone, c1);
                        cmd.head_we  = 1'b1;
                        cmd.head_val = bsum;
                        cmd.cnt_inc  = 1'b1;
                        n_b     = bsum[PW-1:0];
                        n_h2    = head;
                        n_state = S_PUSH2;
                    end
                end else begin
                    meta_we    = 1'b1;
                    meta_waddr = r_page;
                    meta_wdata = {1'b1, r_req};
                    n_used     = r_used + (CW'(1) << r_req);
                    n_status   = ST_DONE;
                    n_res      = r_page;
                    n_state    = S_OUT;
                end
            end
            // push: back link of the old head
            S_PUSH2: begin
                if (r_h2 < LINK_NONE) begin
                    pv_we = 1'b1;  pv_waddr = r_h2[PW-1:0];  pv_wdata = {1'b0, r_b};
                end
                if (r_func == FUNC_FREE) begin
                    n_status = ST_DONE;
                    n_res    = r_in_page;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_A_SPLIT;
                end
            end
            S_F_CHK: begin
                if (!meta_rd[OW]) begin
                    n_status = ST_IGNORED;
                    n_res    = r_in_page;
                    n_state  = S_OUT;
                end else begin
                    n_used  = r_used - (CW'(1) << r_order);
                    n_zone  = ({1'b0, r_page} >= r_dma);
                    n_state = S_F_BUD;
                end
            end
            S_F_BUD: begin
                if (r_order < OW'(TOP_ORDER) && {1'b0, bx} < lim) begin
                    meta_re = 1'b1;  meta_raddr = bx;
                    nx_re   = 1'b1;  nx_raddr   = bx;
                    pv_re   = 1'b1;  pv_raddr   = bx;
                    n_b     = bx;
                    n_state = S_F_BCHK;
                end else begin
                    n_state = S_F_PUSH1;
                end
            end
            // buddy must be a free head of the same order and zone
            S_F_BCHK: begin
                if (!meta_rd[OW] && meta_rd[OW-1:0] == r_order
                        && (({1'b0, r_b} >= r_dma) == r_zone)) begin
                    n_li    = list_idx(r_zone, r_order);
                    n_state = S_UL1;
                end else begin
                    n_state = S_F_PUSH1;
                end
            end
            S_F_PUSH1: begin
                ridx = list_idx(r_zone, r_order);
                meta_we = 1'b1;  meta_waddr = r_page;  meta_wdata = {1'b0, r_order};
                nx_we = 1'b1;    nx_waddr = r_page;    nx_wdata = head;
                pv_we = 1'b1;    pv_waddr = r_page;    pv_wdata = LINK_NONE;
                cmd.idx      = list_idx(r_zone, r_order);
                cmd.head_we  = 1'b1;
                cmd.head_val = {1'b0, r_page};
                cmd.cnt_inc  = 1'b1;
                n_b     = r_page;
                n_h2    = head;
                n_state = S_PUSH2;
            end
            S_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign out_load = (r_state == S_OUT) && (!r_o_valid || !i_stall);

    // state, working registers, configuration and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_used    <= CW'(FRAMES);
            r_total   <= CW'(4096);
            r_kend    <= '0;
            r_dma     <= CW'(4096);
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_used  <= n_used;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TOTAL: r_total <= i_cfg_data;
                    REG_KEND:  r_kend  <= i_cfg_data;
                    REG_DMA:   r_dma   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
        r_func <= n_func;  r_zone <= n_zone;  r_req <= n_req;  r_order <= n_order;
        r_page <= n_page;  r_in_page <= n_in_page;  r_b <= n_b;  r_h2 <= n_h2;
        r_li <= n_li;      r_status <= n_status;    r_res <= n_res;
        if (out_load) begin
            r_o_status <= n_status;
            r_o_page   <= r_res;
            r_o_used   <= r_used;
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_block_page = r_o_page;
    assign o_used_pages = r_o_used;

    // used count only moves at the commit steps
    assign used_hold = (n_used == r_used) || (r_state == S_A_SPLIT) || (r_state == S_F_CHK);
    assign in_walk   = (r_state == S_UL1) || (r_state == S_F_BUD);

    `BPA_ASSERT_NORST(a_rst_clears, !i_rst_n |=> (r_state == S_CLR), "no clearing pass")
    `BPA_ASSERT(a_clr_stalls, (r_state == S_CLR) |-> o_stall, "word taken during clearing pass")
    `BPA_ASSERT(a_used_src, used_hold, "used count moved outside commit")
    `BPA_ASSERT(a_walk_order, in_walk |-> (r_order <= OW'(TOP_ORDER)), "walk order out of range")
endmodule

/* tb/sv/buddy_page_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free words against a cycle-free model of the two-zone
// buddy allocator, compares every result word field by field, and walks
// through several register settings under varying idle and stall patterns.
// ----------------------------------------------------------------------------

// Free-list model plus the queue of expected result words
class buddy_scoreboard;
    localparam int NFR = bpa_pkg::FRAMES;
    localparam int MO  = bpa_pkg::TOP_ORDER;

    bit          used_bit[NFR];
    bit [3:0]    head_order[NFR];
    bit [12:0]   fwd[NFR];
    bit [12:0]   bwd[NFR];
    bit [12:0]   heads[bpa_pkg::LISTS];
    bit [12:0]   counts[bpa_pkg::LISTS];
    bit [10:0]   avail[2];
    bit [12:0]   used_cnt;
    bit [12:0]   total_reg, kend_reg, dma_reg;

    bit [1:0]    exp_status[$];
    bit [11:0]   exp_page[$];
    bit [12:0]   exp_used[$];
    bit [11:0]   held_page[$];
    bit [3:0]    held_order[$];
    int          errors;

    function new();
        for (int i = 0; i < NFR; i++) begin
            used_bit[i] = 1'b1; head_order[i] = '0; fwd[i] = '0; bwd[i] = '0;
        end
        for (int i = 0; i < bpa_pkg::LISTS; i++) begin
            heads[i] = bpa_pkg::LINK_NONE; counts[i] = '0;
        end
        avail[0] = '0; avail[1] = '0;
        used_cnt = 13'd4096;
        total_reg = 13'd4096; kend_reg = '0; dma_reg = 13'd4096;
        errors = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [12:0] val);
        case (idx)
            bpa_pkg::REG_TOTAL: total_reg = val;
            bpa_pkg::REG_KEND:  kend_reg  = val;
            bpa_pkg::REG_DMA:   dma_reg   = val;
            default: ;
        endcase
    endfunction

    function int limit_pages();
        return (total_reg < NFR) ? int'(total_reg) : NFR;
    endfunction

    function int zone_at(int pfn);
        return (pfn < dma_reg) ? 0 : 1;
    endfunction

    function int lidx(int z, int o);
        return z * (MO + 1) + o;
    endfunction

    function void push_block(int z, int o, int x);
        int li;
        bit [12:0] h, was;
        li = lidx(z, o);
        h = heads[li];
        was = counts[li];
        fwd[x] = h;
        bwd[x] = bpa_pkg::LINK_NONE;
        if (h < NFR) bwd[h] = 13'(x);
        heads[li] = 13'(x);
        counts[li] = (was < bpa_pkg::COUNT_TOP) ? was + 13'd1 : bpa_pkg::COUNT_TOP;
        if (was == 0) avail[z][o] = 1'b1;
    endfunction

    function void unlink_block(int z, int o, int x);
        int li;
        bit [12:0] p, n;
        li = lidx(z, o);
        p = bwd[x];
        n = fwd[x];
        if (p < NFR) fwd[p] = n;
        else heads[li] = n;
        if (n < NFR) bwd[n] = p;
        fwd[x] = bpa_pkg::LINK_NONE;
        bwd[x] = bpa_pkg::LINK_NONE;
        if (counts[li] > 0) counts[li]--;
        if (counts[li] == 0) avail[z][o] = 1'b0;
    endfunction

    function bit [1:0] take_block(int o, int z, output bit [11:0] pg);
        int c, h, b, lim;
        lim = limit_pages();
        pg = '0;
        for (c = o; c <= MO; c++)
            if (avail[z][c]) break;
        if (c > MO) return bpa_pkg::ST_NOMEM;
        h = heads[lidx(z, c)];
        if (h >= NFR) return bpa_pkg::ST_NOMEM;
        unlink_block(z, c, h);
        used_bit[h] = 1'b1;
        // split down, upper halves go back on their lists
        while (c > o) begin
            c--;
            b = h + (1 << c);
            if (b < lim) begin
                used_bit[b] = 1'b0;
                head_order[b] = 4'(c);
                push_block(z, c, b);
            end
        end
        head_order[h] = 4'(o);
        used_cnt = used_cnt + 13'(1 << o);
        pg = 12'(h);
        return bpa_pkg::ST_DONE;
    endfunction

    function bit [1:0] release_block(int o, int pfn);
        int lim, z, b;
        lim = limit_pages();
        if (pfn >= lim || !used_bit[pfn] || pfn < kend_reg) return bpa_pkg::ST_IGNORED;
        used_cnt = used_cnt - 13'(1 << o);
        z = zone_at(pfn);
        // merge upward with free buddies of the same order and zone
        while (o < MO) begin
            b = pfn ^ (1 << o);
            if (b >= lim || used_bit[b] || head_order[b] != o || zone_at(b) != z) break;
            unlink_block(z, o, b);
            head_order[b] = bpa_pkg::NOT_HEAD;
            pfn = pfn & b;
            o++;
        end
        used_bit[pfn] = 1'b0;
        head_order[pfn] = 4'(o);
        push_block(z, o, pfn);
        return bpa_pkg::ST_DONE;
    endfunction

    // accepted request word: compute the expected result word
    function void note_request(bit fn, bit [3:0] ord, bit zn, bit [11:0] pg);
        bit [1:0]  st;
        bit [11:0] rp;
        rp = '0;
        if (ord > MO) begin
            st = bpa_pkg::ST_ORDER;
            if (fn == bpa_pkg::FUNC_FREE) rp = pg;
        end else if (fn == bpa_pkg::FUNC_ALLOC) begin
            st = take_block(ord, zn, rp);
            if (st == bpa_pkg::ST_DONE) begin
                held_page.push_back(rp);
                held_order.push_back(ord);
            end
        end else begin
            st = release_block(ord, pg);
            rp = pg;
        end
        exp_status.push_back(st);
        exp_page.push_back(rp);
        exp_used.push_back(used_cnt);
    endfunction

    task report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function bit pending();
        return exp_status.size() != 0;
    endfunction

    // accepted result word: compare with the oldest expectation
    task check_result(bit [1:0] st, bit [11:0] pg, bit [12:0] usd);
        if (exp_status.size() == 0) begin
            report("unexpected result word, status", st, 0);
        end else begin
            if (st != exp_status[0]) report("status", st, exp_status[0]);
            if (pg != exp_page[0]) report("block_page", pg, exp_page[0]);
            if (usd != exp_used[0]) report("used_pages", usd, exp_used[0]);
            void'(exp_status.pop_front());
            void'(exp_page.pop_front());
            void'(exp_used.pop_front());
        end
    endtask
endclass

module buddy_page_allocator_tb;
    import bpa_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_func = 1'b0;
    logic [3:0]  i_order = '0;
    logic        i_zone = 1'b0;
    logic [11:0] i_page = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [11:0] o_block_page;
    logic [12:0] o_used_pages;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [12:0] i_cfg_data = '0;

    buddy_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_req = 1'b0;
    bit  hold_seen = 0;
    int  hold_left = 0;
    int  cycles = 0;

    buddy_page_allocator DUT (.*);

    // clock, period 8 ns
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: check accepted words, pick the next stall value
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_status, o_block_page, o_used_pages);
        if (hold_req && !hold_seen) begin
            hold_seen = 1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // offer one request word and wait until it is taken
    task send_word(bit fn, bit [3:0] ord, bit zn, bit [11:0] pg);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= fn;
        i_order <= ord;
        i_zone  <= zn;
        i_page  <= pg;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(fn, ord, zn, pg);
    endtask

    // wait until every expected word is back, then let the block settle
    task drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending()) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // one register write, strobe dropped again before the model takes the value
    task write_cfg(bit [1:0] idx, bit [12:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // one random word: mostly well-formed traffic, some noise
    task random_word;
        int r, k;
        bit [3:0] o;
        r = $urandom_range(0, 99);
        if (r < 8 || (sb.held_page.size() == 0 && r < 30)) begin
            // hand memory back in blocks at aligned pages, mostly of order 10
            send_word(FUNC_FREE, $urandom_range(0, 1) ? 4'd10 : 4'($urandom_range(0, 10)),
                      1'($urandom), 12'($urandom_range(0, 3) * 1024));
        end else if (r < 50) begin
            o = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 10))
                                            : 4'($urandom_range(0, 3));
            send_word(FUNC_ALLOC, o, 1'($urandom), 12'($urandom));
        end else if (r < 85 && sb.held_page.size() != 0) begin
            k = $urandom_range(0, sb.held_page.size() - 1);
            send_word(FUNC_FREE, sb.held_order[k], 1'($urandom), sb.held_page[k]);
            sb.held_page.delete(k);
            sb.held_order.delete(k);
        end else begin
            send_word(1'($urandom), 4'($urandom_range(0, 15)), 1'($urandom), 12'($urandom));
        end
    endtask

    initial begin
        int tot[6], kend[6], dma[6];
        tot  = '{4096, 1000, 4096, 0, 4096, 3000};
        kend = '{0, 16, 4096, 0, 200, 0};
        dma  = '{4096, 512, 2048, 0, 0, 1536};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: register writes, extremes, every status
        write_cfg(REG_TOTAL, 13'd4096);
        write_cfg(REG_KEND, 13'd0);
        write_cfg(REG_DMA, 13'd4096);
        send_word(FUNC_ALLOC, 4'd0, 1'b0, 12'd0);       // nothing free yet
        send_word(FUNC_ALLOC, 4'd11, 1'b1, 12'hfff);    // order too large
        send_word(FUNC_FREE, 4'd15, 1'b0, 12'hfff);
        send_word(FUNC_FREE, 4'd10, 1'b0, 12'd0);
        send_word(FUNC_FREE, 4'd10, 1'b1, 12'd0);       // already free
        send_word(FUNC_FREE, 4'd10, 1'b0, 12'd1024);
        send_word(FUNC_FREE, 4'd0, 1'b1, 12'hfff);
        send_word(FUNC_FREE, 4'd0, 1'b0, 12'hffe);      // merges with its buddy
        send_word(FUNC_ALLOC, 4'd1, 1'b1, 12'd0);       // normal zone empty
        send_word(FUNC_ALLOC, 4'd0, 1'b0, 12'hfff);     // splits the order-1 block at page 0xffe
        send_word(FUNC_ALLOC, 4'd10, 1'b0, 12'd0);
        send_word(FUNC_ALLOC, 4'd10, 1'b0, 12'd0);
        send_word(FUNC_ALLOC, 4'd3, 1'b0, 12'd5);
        send_word(FUNC_FREE, 4'd0, 1'b0, 12'd0);
        drain();
        // page range cut short: halves past the end are dropped
        write_cfg(REG_TOTAL, 13'd1030);
        write_cfg(REG_KEND, 13'd4);
        send_word(FUNC_FREE, 4'd10, 1'b0, 12'd2048);    // unmanaged
        send_word(FUNC_FREE, 4'd0, 1'b0, 12'd2);        // kernel-owned
        send_word(FUNC_FREE, 4'd10, 1'b0, 12'd1024);
        send_word(FUNC_ALLOC, 4'd0, 1'b0, 12'd0);
        send_word(FUNC_ALLOC, 4'd3, 1'b0, 12'd0);
        drain();

        // random phases: receiver stalls, then sender idles, then neither but one long hold
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(REG_TOTAL, 13'(tot[ph]));
            write_cfg(REG_KEND, 13'(kend[ph]));
            write_cfg(REG_DMA, 13'(dma[ph]));
            send_idle_pct  = (ph < 2) ? 9 : (ph < 4) ? 59 : 0;
            recv_stall_pct = (ph < 2) ? 59 : (ph < 4) ? 9 : 0;
            if (ph == 4) hold_req <= 1'b1;
            for (int n = 0; n < 205; n++) random_word();
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && !sb.pending())
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
